FILE: rtl/core/cartridge_bank_controller_defines.svh
// ----------------------------------------------------------------------------
// Cartridge bank controller: assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define CBC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cartridge bank controller: same-cycle check failed");

// Check that a condition implies another in the next cycle
`define CBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cartridge bank controller: next-cycle check failed");

`endif

FILE: rtl/core/cbc_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Mapper and request codes, and the access descriptor passed to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbc_pkg;

  // Mapper kinds
  localparam logic [1:0] MAPPER_PLAIN = 2'd0;
  localparam logic [1:0] MAPPER_MBC1  = 2'd1;
  localparam logic [1:0] MAPPER_MBC2  = 2'd2;
  localparam logic [1:0] MAPPER_MBC3  = 2'd3;

  // Request kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Fixed read values in the RAM window
  localparam logic [7:0] RAM_DISABLED_DATA = 8'hFF;
  localparam logic [7:0] CLOCK_READ_DATA   = 8'h00;

  localparam int unsigned ROM_ADDR_W = 21;

  // Decoded access for one request
  typedef struct packed {
    logic                  rd_ram;
    logic                  wr_ram;
    logic                  from_rom;
    logic [7:0]            fixed_data;
    logic [ROM_ADDR_W-1:0] rom_address;
  } access_t;

endpackage

`default_nettype wire

FILE: rtl/core/cbc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cbc_bank_regs.sv
// ----------------------------------------------------------------------------
// Cartridge bank registers and access decode
// Holds the bank state, applies bank writes and decodes each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbc_bank_regs #(
  parameter int EXT_RAM_BYTES = 32768,
  parameter int ROM_BANK_BITS = 7
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic [1:0]                       mapper_type,
  input  wire logic                             req_type,
  input  wire logic [15:0]                      bus_address,
  input  wire logic [7:0]                       write_data,
  output cbc_pkg::access_t                      acc,
  output logic      [$clog2(EXT_RAM_BYTES)-1:0] ram_idx
);

  localparam int RBB = ROM_BANK_BITS;
  localparam int AW  = $clog2(EXT_RAM_BYTES);
  localparam logic [16:0] SIZE_1 = 17'(EXT_RAM_BYTES);
  localparam logic [16:0] SIZE_2 = 17'(2 * EXT_RAM_BYTES);
  localparam logic [16:0] SIZE_3 = 17'(3 * EXT_RAM_BYTES);

  logic [RBB-1:0] rom_bank, rom_bank_next;
  logic [1:0]     ram_bank, ram_bank_next;
  logic           ram_enable, ram_enable_next;
  logic           ram_bank_mode, ram_bank_mode_next;
  logic           clock_selected, clock_selected_next;

  logic           is_write, in_ram, enable_bit;
  logic [6:0]     bank7, lo7, hi7;
  logic [RBB-1:0] lo_m, hi_m, m3_m;
  logic [RBB-1:0] mbc1_lo_bank, mbc1_hi_bank, mbc3_bank;
  logic [1:0]     eff_bank;
  logic [16:0]    raw_idx, wrap_sub, wrapped;

  assign is_write   = (req_type == cbc_pkg::REQ_WRITE);
  assign in_ram     = (bus_address[15:13] == 3'b101);
  assign enable_bit = |(write_data & 8'h0A);

  // Candidate ROM banks, masked to width and kept off bank zero
  assign bank7 = 7'(rom_bank);
  assign lo7   = {bank7[6:5], write_data[4:0]};
  assign hi7   = {write_data[1:0], bank7[4:0]};
  assign lo_m  = lo7[RBB-1:0];
  assign hi_m  = hi7[RBB-1:0];
  assign m3_m  = write_data[RBB-1:0];
  assign mbc1_lo_bank = (lo_m[4:0] == 5'd0) ? (lo_m | RBB'(1)) : lo_m;
  assign mbc1_hi_bank = (hi_m[4:0] == 5'd0) ? (hi_m | RBB'(1)) : hi_m;
  assign mbc3_bank    = (m3_m == '0) ? RBB'(1) : m3_m;

  // RAM bank in use, and byte index wrapped to the RAM size
  always_comb begin
    unique case (mapper_type)
      cbc_pkg::MAPPER_MBC1:  eff_bank = ram_bank_mode ? ram_bank : 2'd0;
      cbc_pkg::MAPPER_MBC3:  eff_bank = ram_bank;
      cbc_pkg::MAPPER_PLAIN,
      cbc_pkg::MAPPER_MBC2:  eff_bank = 2'd0;
      default:               eff_bank = 2'd0;
    endcase
  end

  assign raw_idx  = {2'b00, eff_bank, bus_address[12:0]};
  assign wrap_sub = (raw_idx >= SIZE_3) ? SIZE_3 :
                    (raw_idx >= SIZE_2) ? SIZE_2 :
                    (raw_idx >= SIZE_1) ? SIZE_1 : 17'd0;
  assign wrapped  = raw_idx - wrap_sub;
  assign ram_idx  = wrapped[AW-1:0];

  // Bank register updates on write requests
  always_comb begin
    rom_bank_next       = rom_bank;
    ram_bank_next       = ram_bank;
    ram_enable_next     = ram_enable;
    ram_bank_mode_next  = ram_bank_mode;
    clock_selected_next = clock_selected;
    if (accept && is_write) begin
      unique case (mapper_type)
        cbc_pkg::MAPPER_MBC1: begin
          unique case (bus_address[15:13])
            3'd0: ram_enable_next = enable_bit;
            3'd1: rom_bank_next = mbc1_lo_bank;
            3'd2: begin
              if (ram_bank_mode) begin
                ram_bank_next = write_data[1:0];
              end else begin
                rom_bank_next = mbc1_hi_bank;
              end
            end
            3'd3: ram_bank_mode_next = write_data[0];
            default: ;
          endcase
        end
        cbc_pkg::MAPPER_MBC3: begin
          unique case (bus_address[15:13])
            3'd0: begin
              ram_enable_next     = enable_bit;
              clock_selected_next = enable_bit;
            end
            3'd1: rom_bank_next = mbc3_bank;
            3'd2: begin
              if (write_data <= 8'h03) begin
                clock_selected_next = 1'b0;
                ram_bank_next       = write_data[1:0];
              end else if (write_data >= 8'h08 && write_data <= 8'h0C) begin
                clock_selected_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
        cbc_pkg::MAPPER_PLAIN,
        cbc_pkg::MAPPER_MBC2: ;
        default: ;
      endcase
    end
  end

  // Hold the bank registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank       <= RBB'(1);
      ram_bank       <= 2'd0;
      ram_enable     <= 1'b0;
      ram_bank_mode  <= 1'b0;
      clock_selected <= 1'b0;
    end else begin
      rom_bank       <= rom_bank_next;
      ram_bank       <= ram_bank_next;
      ram_enable     <= ram_enable_next;
      ram_bank_mode  <= ram_bank_mode_next;
      clock_selected <= clock_selected_next;
    end
  end

  // Decode the request into a RAM access, ROM address or fixed value
  always_comb begin
    acc = '0;
    if (is_write) begin
      unique case (mapper_type)
        cbc_pkg::MAPPER_PLAIN: acc.wr_ram = in_ram;
        cbc_pkg::MAPPER_MBC1:  acc.wr_ram = in_ram && ram_enable;
        cbc_pkg::MAPPER_MBC3:  acc.wr_ram = in_ram && ram_enable && !clock_selected;
        cbc_pkg::MAPPER_MBC2:  acc.wr_ram = 1'b0;
        default:               acc.wr_ram = 1'b0;
      endcase
    end else begin
      unique case (mapper_type)
        cbc_pkg::MAPPER_PLAIN: begin
          if (!bus_address[15]) begin
            acc.from_rom    = 1'b1;
            acc.rom_address = 21'(bus_address);
          end else if (in_ram) begin
            acc.rd_ram = 1'b1;
          end
        end
        cbc_pkg::MAPPER_MBC1,
        cbc_pkg::MAPPER_MBC3: begin
          if (bus_address[15:14] == 2'b00) begin
            acc.from_rom    = 1'b1;
            acc.rom_address = 21'(bus_address);
          end else if (bus_address[15:14] == 2'b01) begin
            acc.from_rom    = 1'b1;
            acc.rom_address = 21'({rom_bank, bus_address[13:0]});
          end else if (in_ram) begin
            if (mapper_type == cbc_pkg::MAPPER_MBC3 && clock_selected) begin
              acc.fixed_data = cbc_pkg::CLOCK_READ_DATA;
            end else if (!ram_enable) begin
              acc.fixed_data = cbc_pkg::RAM_DISABLED_DATA;
            end else begin
              acc.rd_ram = 1'b1;
            end
          end
        end
        cbc_pkg::MAPPER_MBC2: ;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/cartridge_bank_controller.sv
// Results: the RAM read issues at acceptance and its data is registered, then
// the output register takes it. Throughput: one request per cycle, set by the
// single RAM port, while the output is not stalled.
// Reset: bank registers and mapper_type go to their defaults; a clearing pass
// over all EXT_RAM_BYTES addresses (32768 by default) zeroes the RAM, during
// which no request is taken. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// Cartridge bank controller
// Handheld cartridge mapper (plain, MBC1, MBC3; MBC2 gives no access) with banked external RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cartridge_bank_controller_defines.svh"

module cartridge_bank_controller #(
  parameter int EXT_RAM_BYTES = 32768,
  parameter int ROM_BANK_BITS = 7
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: mapper_type
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,
  // Requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [15:0] bus_address, [23:16] write_data
  input  wire logic        s_tuser,   // [0] req_type
  // Results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [7:0] read_data, [28:8] rom_address, [31:29] zero
  output logic             m_tuser    // [0] from_rom
);

  localparam int AW = $clog2(EXT_RAM_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(EXT_RAM_BYTES - 1);

  logic [1:0]       mapper_type;
  logic             clr_busy;
  logic [AW-1:0]    clr_addr;
  logic             accept;
  cbc_pkg::access_t acc;
  logic [AW-1:0]    ram_idx;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_addr;
  logic [7:0]       ram_wdata, ram_rdata;

  logic             pend_valid, pend_move;
  cbc_pkg::access_t pend_acc;
  logic             out_valid;
  logic [7:0]       out_data;
  logic             out_rom;
  logic [20:0]      out_addr;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign pend_move = pend_valid && (!out_valid || m_tready);
  assign s_tready  = !clr_busy && (!pend_valid || pend_move);

  // Hold the mapper kind
  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_type <= cbc_pkg::MAPPER_PLAIN;
    end else if (cfg_valid && cfg_ready) begin
      mapper_type <= cfg_data;
    end
  end

  // Sweep the RAM to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == CLR_LAST) begin
        clr_busy <= 1'b0;
      end
    end
  end

  cbc_bank_regs #(
    .EXT_RAM_BYTES (EXT_RAM_BYTES),
    .ROM_BANK_BITS (ROM_BANK_BITS)
  ) u_bank_regs (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .mapper_type (mapper_type),
    .req_type    (s_tuser),
    .bus_address (s_tdata[15:0]),
    .write_data  (s_tdata[23:16]),
    .acc         (acc),
    .ram_idx     (ram_idx)
  );

  // Steer the RAM port between the clearing sweep and requests
  assign ram_we    = clr_busy || (accept && acc.wr_ram);
  assign ram_re    = accept && acc.rd_ram;
  assign ram_addr  = clr_busy ? clr_addr : ram_idx;
  assign ram_wdata = clr_busy ? 8'h00 : s_tdata[23:16];

  cbc_ram #(
    .WIDTH (8),
    .DEPTH (EXT_RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Hold the decoded request while its RAM read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_acc <= acc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_data <= pend_acc.rd_ram ? ram_rdata : pend_acc.fixed_data;
      out_rom  <= pend_acc.from_rom;
      out_addr <= pend_acc.rom_address;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_addr, out_data};
  assign m_tuser  = out_rom;

  // Checks
  `CBC_ASSERT_SAME(a_no_req_while_clearing, clr_busy, !s_tready)
  `CBC_ASSERT_SAME(a_no_read_while_clearing, clr_busy, !ram_re)
  `CBC_ASSERT_NEXT(a_accept_fills_pending, accept, pend_valid)

endmodule

`default_nettype wire

FILE: bench/cartridge_bank_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank controller testbench
// Sends CPU bus reads and writes under every mapper setting. A directed table
// comes first, then random traffic made mostly of bank selects, RAM enables
// and RAM-window accesses. Each result is checked against a predictor of the
// bank registers and the external RAM, or against a typed table entry, with
// random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_test;
  import cbc_pkg::*;

  localparam int RAM_BYTES     = 32768;
  localparam int PHASE_LENGTH  = 135;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AFTER    = 600;
  localparam logic TYPED       = 1'b1;
  localparam logic PREDICTED   = 1'b0;

  typedef struct packed {
    logic [7:0]            read_data;
    logic                  from_rom;
    logic [ROM_ADDR_W-1:0] rom_address;
  } cart_result_t;

  typedef struct packed {
    logic [1:0]   mapper;
    logic         kind;
    logic [15:0]  addr;
    logic [7:0]   data;
    logic         typed;
    cart_result_t result;
  } access_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = 2'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'd0;   // [15:0] bus_address, [23:16] write_data
  logic        s_tuser = 1'b0;    // [0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [7:0] read_data, [28:8] rom_address
  logic        m_tuser;           // [0] from_rom

  // Mirror of the cartridge state
  logic [1:0]  mapper_sel = MAPPER_PLAIN;
  logic [6:0]  rom_bank_q = 7'd1;
  logic [1:0]  ram_bank_q = 2'd0;
  logic        ram_on = 1'b0;
  logic        bank_mode = 1'b0;
  logic        clock_sel = 1'b0;
  bit   [7:0]  cart_ram [RAM_BYTES];

  cart_result_t awaited_results [$];
  access_row_t  access_table [$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned reads_sent = 0;
  int unsigned writes_sent = 0;
  int unsigned ram_bytes_read = 0;
  int unsigned burst_left = 0;
  bit          sender_no_gaps = 1'b0;

  cartridge_bank_controller dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hold the low five bank bits away from zero
  function automatic void mbc1_bank_floor();
    if (rom_bank_q[4:0] == 5'd0) begin
      rom_bank_q[0] = 1'b1;
    end
  endfunction

  // Apply one bus access to the mirror and return the result it gives
  function automatic cart_result_t predict_access(logic kind, logic [15:0] addr,
                                                  logic [7:0] data);
    cart_result_t res;
    logic         in_ram;
    res    = '0;
    in_ram = (addr >= 16'hA000) && (addr <= 16'hBFFF);
    if (kind == REQ_WRITE) begin
      case (mapper_sel)
        MAPPER_PLAIN: begin
          if (in_ram) cart_ram[{2'b00, addr[12:0]}] = data;
        end
        MAPPER_MBC1: begin
          if (addr <= 16'h1FFF) begin
            ram_on = |(data & 8'h0A);
          end else if (addr <= 16'h3FFF) begin
            rom_bank_q = {rom_bank_q[6:5], data[4:0]};
            mbc1_bank_floor();
          end else if (addr <= 16'h5FFF) begin
            if (bank_mode) begin
              ram_bank_q = data[1:0];
            end else begin
              rom_bank_q = {data[1:0], rom_bank_q[4:0]};
              mbc1_bank_floor();
            end
          end else if (addr <= 16'h7FFF) begin
            bank_mode = data[0];
          end else if (in_ram && ram_on) begin
            cart_ram[{bank_mode ? ram_bank_q : 2'b00, addr[12:0]}] = data;
          end
        end
        MAPPER_MBC3: begin
          if (addr <= 16'h1FFF) begin
            ram_on    = |(data & 8'h0A);
            clock_sel = ram_on;
          end else if (addr <= 16'h3FFF) begin
            rom_bank_q = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];
          end else if (addr <= 16'h5FFF) begin
            if (data <= 8'h03) begin
              clock_sel  = 1'b0;
              ram_bank_q = data[1:0];
            end else if (data >= 8'h08 && data <= 8'h0C) begin
              clock_sel = 1'b1;
            end
          end else if (in_ram && !clock_sel && ram_on) begin
            cart_ram[{ram_bank_q, addr[12:0]}] = data;
          end
        end
        default: begin
        end
      endcase
    end else begin
      case (mapper_sel)
        MAPPER_PLAIN: begin
          if (addr <= 16'h7FFF) begin
            res.from_rom    = 1'b1;
            res.rom_address = {5'd0, addr};
          end else if (in_ram) begin
            res.read_data = cart_ram[{2'b00, addr[12:0]}];
            ram_bytes_read++;
          end
        end
        MAPPER_MBC1, MAPPER_MBC3: begin
          if (addr <= 16'h3FFF) begin
            res.from_rom    = 1'b1;
            res.rom_address = {5'd0, addr};
          end else if (addr <= 16'h7FFF) begin
            res.from_rom    = 1'b1;
            res.rom_address = {rom_bank_q, addr[13:0]};
          end else if (in_ram) begin
            if (mapper_sel == MAPPER_MBC3 && clock_sel) begin
              res.read_data = CLOCK_READ_DATA;
            end else if (!ram_on) begin
              res.read_data = RAM_DISABLED_DATA;
            end else if (mapper_sel == MAPPER_MBC1) begin
              res.read_data = cart_ram[{bank_mode ? ram_bank_q : 2'b00, addr[12:0]}];
              ram_bytes_read++;
            end else begin
              res.read_data = cart_ram[{ram_bank_q, addr[12:0]}];
              ram_bytes_read++;
            end
          end
        end
        default: begin
        end
      endcase
    end
    return res;
  endfunction

  function automatic access_row_t access_row(logic [1:0] mapper, logic kind,
                                             logic [15:0] addr, logic [7:0] data,
                                             logic typed, logic [7:0] rd, logic rom,
                                             logic [ROM_ADDR_W-1:0] raddr);
    access_row_t r;
    r.mapper             = mapper;
    r.kind               = kind;
    r.addr               = addr;
    r.data               = data;
    r.typed              = typed;
    r.result.read_data   = rd;
    r.result.from_rom    = rom;
    r.result.rom_address = raddr;
    return r;
  endfunction

  // Offer one request, pausing between bursts, and record its expected result
  task automatic push_request(input logic kind, input logic [15:0] addr,
                              input logic [7:0] data, input logic typed,
                              input cart_result_t typed_result);
    int unsigned  gap;
    cart_result_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_no_gaps) begin
        gap = 0;
      end else if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(8, 20);
      end else begin
        gap = $urandom_range(0, 4);
      end
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {data, addr};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    want = predict_access(kind, addr, data);
    if (typed) want = typed_result;
    awaited_results.push_back(want);
    if (kind == REQ_WRITE) writes_sent++;
    else reads_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle_requests();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic program_mapper(input logic [1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mapper_sel = value;
  endtask

  // Random traffic under one mapper: mostly register writes and RAM-window use
  task automatic run_random_phase(input logic [1:0] mapper, input bit no_gaps);
    int unsigned pick;
    logic        kind;
    logic [15:0] addr;
    logic [7:0]  data;
    settle_requests();
    program_mapper(mapper);
    sender_no_gaps = no_gaps;
    repeat (PHASE_LENGTH) begin
      pick = $urandom_range(0, 99);
      kind = REQ_WRITE;
      data = 8'($urandom);
      if (pick < 10) begin
        kind = 1'($urandom_range(0, 1));
        addr = 16'($urandom);
      end else if (pick < 22) begin
        addr = 16'($urandom_range(16'h0000, 16'h1FFF));
        if ($urandom_range(0, 3) != 0) data = $urandom_range(0, 1) ? 8'h0A : 8'h00;
        if ($urandom_range(0, 9) == 0) kind = REQ_READ;
      end else if (pick < 32) begin
        addr = 16'($urandom_range(16'h2000, 16'h3FFF));
      end else if (pick < 42) begin
        addr = 16'($urandom_range(16'h4000, 16'h5FFF));
        case ($urandom_range(0, 3))
          0, 1: data = 8'($urandom_range(8'h00, 8'h03));
          2:    data = 8'($urandom_range(8'h08, 8'h0C));
          default: begin
          end
        endcase
      end else if (pick < 48) begin
        addr = 16'($urandom_range(16'h6000, 16'h7FFF));
      end else if (pick < 63) begin
        kind = REQ_READ;
        addr = 16'($urandom_range(16'h0000, 16'h7FFF));
      end else if (pick < 95) begin
        kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1) addr = 16'hA000 + 16'($urandom_range(0, 31));
        else addr = 16'hA000 + 16'($urandom_range(0, 16'h1FFF));
      end else begin
        kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1) addr = 16'h8000 + 16'($urandom_range(0, 16'h1FFF));
        else addr = 16'hC000 + 16'($urandom_range(0, 16'h3FFF));
      end
      push_request(kind, addr, data, PREDICTED, '0);
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    cart_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result with no request waiting: data %0h user %0h", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (m_tdata[7:0] !== want.read_data) begin
          $error("read_data: expected %0h, got %0h", want.read_data, m_tdata[7:0]);
          mismatches++;
        end
        if (m_tuser !== want.from_rom) begin
          $error("from_rom: expected %0h, got %0h", want.from_rom, m_tuser);
          mismatches++;
        end
        if (m_tdata[28:8] !== want.rom_address) begin
          $error("rom_address: expected %0h, got %0h", want.rom_address, m_tdata[28:8]);
          mismatches++;
        end
      end
    end
  end

  // Stall the result side on a shifting pattern, with one long hold-off
  initial begin : result_sink
    int unsigned ready_cycle;
    bit          held;
    ready_cycle = 0;
    held        = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      ready_cycle++;
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      case (ready_cycle[9:7])
        3'd0, 3'd1: m_tready <= 1'b1;
        3'd2:       m_tready <= ($urandom_range(0, 1) == 1);
        3'd3:       m_tready <= (ready_cycle[2:0] != 3'b101);
        3'd4:       m_tready <= (ready_cycle[3:0] < 4'd4);
        3'd5:       m_tready <= ($urandom_range(0, 7) != 0);
        default:    m_tready <= (ready_cycle[4] == 1'b0);
      endcase
    end
  end

  initial begin : stimulus
    access_row_t r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed requests: extremes, every mapper, the quirks of each
    access_table.push_back(access_row(MAPPER_PLAIN, REQ_READ,  16'h7FFF, 8'h00, TYPED,
                                      8'h00, 1'b1, 21'h007FFF));
    access_table.push_back(access_row(MAPPER_PLAIN, REQ_READ,  16'hA000, 8'hFF, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_PLAIN, REQ_WRITE, 16'hBFFF, 8'hFF, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_PLAIN, REQ_READ,  16'hBFFF, 8'h00, TYPED,
                                      8'hFF, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_PLAIN, REQ_READ,  16'hFFFF, 8'h00, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_READ,  16'hA000, 8'h00, TYPED,
                                      8'hFF, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_WRITE, 16'h0000, 8'h0A, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_WRITE, 16'h2000, 8'h00, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_READ,  16'h4000, 8'h00, TYPED,
                                      8'h00, 1'b1, 21'h004000));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_WRITE, 16'h4000, 8'h03, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_READ,  16'h7FFF, 8'h00, PREDICTED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_WRITE, 16'h6000, 8'h01, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_WRITE, 16'h5FFF, 8'h02, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_WRITE, 16'hA123, 8'h5A, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_READ,  16'hA123, 8'h00, PREDICTED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_WRITE, 16'h1FFF, 8'h00, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC1,  REQ_READ,  16'hA123, 8'h00, TYPED,
                                      8'hFF, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC2,  REQ_WRITE, 16'h2000, 8'h1F, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC2,  REQ_READ,  16'h0000, 8'h00, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC3,  REQ_WRITE, 16'h0000, 8'h02, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC3,  REQ_READ,  16'hA000, 8'h00, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC3,  REQ_WRITE, 16'h4000, 8'h03, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC3,  REQ_WRITE, 16'hA000, 8'h77, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC3,  REQ_READ,  16'hA000, 8'h00, PREDICTED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC3,  REQ_WRITE, 16'h4000, 8'h0C, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC3,  REQ_READ,  16'hBFFF, 8'h00, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC3,  REQ_WRITE, 16'h2000, 8'h80, TYPED,
                                      8'h00, 1'b0, 21'h0));
    access_table.push_back(access_row(MAPPER_MBC3,  REQ_READ,  16'h7FFF, 8'h00, PREDICTED,
                                      8'h00, 1'b0, 21'h0));

    foreach (access_table[i]) begin
      r = access_table[i];
      if (r.mapper != mapper_sel) begin
        settle_requests();
        program_mapper(r.mapper);
      end
      push_request(r.kind, r.addr, r.data, r.typed, r.result);
    end

    // Random phases across every mapper setting; one runs with no gaps
    run_random_phase(MAPPER_MBC1,  1'b0);
    run_random_phase(MAPPER_MBC3,  1'b1);
    run_random_phase(MAPPER_PLAIN, 1'b0);
    run_random_phase(MAPPER_MBC1,  1'b0);
    run_random_phase(MAPPER_MBC3,  1'b0);
    run_random_phase(MAPPER_MBC2,  1'b0);
    run_random_phase(MAPPER_MBC3,  1'b0);
    run_random_phase(MAPPER_MBC1,  1'b0);

    settle_requests();
    repeat (10) @(posedge clk);

    $display("Checked %0d results from %0d reads and %0d writes under all four mappers.",
             results_seen, reads_sent, writes_sent);
    $display("%0d RAM-window reads returned stored bytes; one long result stall.",
             ram_bytes_read);
    if (mismatches == 0) begin
      $display("PASS cartridge_bank_controller");
    end else begin
      $display("FAIL cartridge_bank_controller");
    end
    $finish;
  end

  // End a hung run
  initial begin : watchdog
    #5_000_000;
    $display("FAIL cartridge_bank_controller");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/cbc_pkg.sv
rtl/core/cbc_ram.sv
rtl/core/cbc_bank_regs.sv
rtl/core/cartridge_bank_controller.sv
bench/cartridge_bank_controller_test.sv
